/* src/sliding_window_median_alert_core_macros.svh */
// Assertion macros shared by the sliding window median alert RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SLIDING_WINDOW_MEDIAN_ALERT_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_ALERT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWMA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SWMA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/swma_pkg.sv */
// Shared types and constants for the sliding window median alert block.
// No dependencies.
`default_nettype none
package swma_pkg;
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int LEN_BITS        = 7;
   localparam int COUNT_BITS      = 32;

   // commands from controller to datapath
   typedef struct packed {
      logic load;     // take request word
      logic check;    // fullness, median and oldest read
      logic del;      // alert and delete oldest from sorted cells
      logic ins;      // insert new sample
      logic publish;  // load result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

/* src/swma_if.sv */
// Handshake interfaces for request and response words.
// Depends on nothing; widths follow SAMPLE_BITS.
`default_nettype none
interface swma_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   start_series;
   modport source (output valid, sample, start_series, input ready);
   modport sink   (input valid, sample, start_series, output ready);
endinterface

interface swma_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   window_full;
   logic [SAMPLE_BITS:0]   median_times_two;
   logic                   alert;
   logic [31:0]            alert_count;
   modport source (output valid, window_full, median_times_two, alert, alert_count,
                   input ready);
   modport sink   (input valid, window_full, median_times_two, alert, alert_count,
                    output ready);
endinterface
`default_nettype wire

/* src/swma_ctrl.sv */
// Sequencer for one word: check, delete (only when the window is full), insert, publish.
// Depends on swma_pkg and the assertion macro header.
`default_nettype none
`include "sliding_window_median_alert_core_macros.svh"
module swma_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire swma_pkg::sts_type sts,
   output swma_pkg::cmd_type      cmd
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DEL   = 3'd2;
   localparam logic [2:0] ST_INS   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_DEL;
         end
         ST_DEL: begin
            // full flag was settled in the check cycle
            if (sts.full) cmd.del = 1'b1;
            state_in = ST_INS;
         end
         ST_INS: begin
            cmd.ins  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `SWMA_ASSERT_NXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == ST_CHECK)
   `SWMA_ASSERT_IMP(a_del_needs_full, clock, reset, cmd.del, sts.full)
   `SWMA_ASSERT_IMP(a_publish_free, clock, reset, cmd.publish, sts.out_free)
   `SWMA_ASSERT_NXT(a_ins_to_out, clock, reset, cmd.ins, state_ff == ST_OUT)
endmodule
`default_nettype wire

/* src/swma_dp.sv */
// Datapath: arrival ring memory, sorted cell chain, median, alert count.
// Depends on swma_pkg.
`default_nettype none
module swma_dp #(
   parameter int WINDOW_MAX  = swma_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire swma_pkg::cmd_type               cmd,
   output swma_pkg::sts_type                    sts,
   input  wire logic [SAMPLE_BITS-1:0]          req_sample,
   input  wire logic                            req_start_series,
   input  wire logic                            csr_we,
   input  wire logic [swma_pkg::LEN_BITS-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_window_full,
   output logic [SAMPLE_BITS:0]                 rsp_median_times_two,
   output logic                                 rsp_alert,
   output logic [swma_pkg::COUNT_BITS-1:0]      rsp_alert_count
);
   localparam int FW = $clog2(WINDOW_MAX + 1);
   localparam int HW = $clog2(WINDOW_MAX);
   localparam int SB = SAMPLE_BITS;
   localparam int CB = swma_pkg::COUNT_BITS;

   logic [swma_pkg::LEN_BITS-1:0] len_ff;
   logic [FW-1:0]  fill_ff, eff_len;
   logic [HW-1:0]  head_ff, old_idx, med_hi, med_lo;
   logic [SB-1:0]  samp_ff, old_ff;
   logic [SB:0]    med2_ff;
   logic           full_ff, alert_ff;
   logic [CB-1:0]  total_ff;
   logic [SB-1:0]  ring_mem [WINDOW_MAX];
   logic [SB-1:0]  cell_ff  [WINDOW_MAX];
   logic [SB-1:0]  del_cell [WINDOW_MAX];
   logic [SB-1:0]  ins_cell [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] hit, gt;
   logic           hit_run;
   logic           rsp_valid_ff;
   logic           rsp_full_ff, rsp_alert_ff;
   logic [SB:0]    rsp_med2_ff;
   logic [CB-1:0]  rsp_count_ff;

   // effective window length: zero acts as one, clamp at the maximum
   always_comb begin
      if (len_ff == '0)                     eff_len = FW'(1);
      else if (int'(len_ff) > WINDOW_MAX)   eff_len = FW'(WINDOW_MAX);
      else                                  eff_len = FW'(len_ff);
   end

   // oldest slot, modulo the ring size
   always_comb begin
      if ({1'b0, head_ff} >= (HW+1)'(fill_ff))
         old_idx = HW'({1'b0, head_ff} - (HW+1)'(fill_ff));
      else
         old_idx = HW'((HW+1)'(head_ff) + (HW+1)'(WINDOW_MAX) - (HW+1)'(fill_ff));
   end

   // middle cells; lo equals hi for an odd count
   assign med_hi = HW'(fill_ff >> 1);
   assign med_lo = fill_ff[0] ? med_hi : HW'(med_hi - HW'(1));

   // delete: every cell from the first match onward takes its upper neighbour
   always_comb begin
      hit_run = 1'b0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         hit_run = hit_run || ((i < int'(fill_ff)) && (cell_ff[i] == old_ff));
         hit[i]  = hit_run;
         if (hit[i] && (i + 1 < WINDOW_MAX)) del_cell[i] = cell_ff[(i + 1) % WINDOW_MAX];
         else                                del_cell[i] = cell_ff[i];
      end
   end

   // insert: cells above the sample move up by one
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         gt[i] = (i < int'(fill_ff)) && (cell_ff[i] > samp_ff);
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (i > int'(fill_ff))                      ins_cell[i] = cell_ff[i];
         else if (!gt[i] && (i < int'(fill_ff)))     ins_cell[i] = cell_ff[i];
         else if ((i > 0) && gt[(i + WINDOW_MAX - 1) % WINDOW_MAX])
            ins_cell[i] = cell_ff[(i + WINDOW_MAX - 1) % WINDOW_MAX];
         else                                        ins_cell[i] = samp_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= swma_pkg::LEN_BITS'(1);
         fill_ff  <= '0;
         head_ff  <= '0;
         total_ff <= '0;
      end else if (csr_we) begin
         len_ff  <= csr_wdata;
         fill_ff <= '0;
         head_ff <= '0;
      end else begin
         if (cmd.load && req_start_series) begin
            fill_ff  <= '0;
            head_ff  <= '0;
            total_ff <= '0;
         end
         if (cmd.del) begin
            fill_ff <= FW'(fill_ff - FW'(1));
            if (({1'b0, samp_ff} >= med2_ff) && (total_ff != '1))
               total_ff <= total_ff + CB'(1);
         end
         if (cmd.ins) begin
            fill_ff <= FW'(fill_ff + FW'(1));
            if (int'(head_ff) == WINDOW_MAX - 1) head_ff <= '0;
            else                                 head_ff <= HW'(head_ff + HW'(1));
         end
      end
   end

   // payload registers and ring memory
   always_ff @(posedge clock) begin
      if (cmd.load) samp_ff <= req_sample;
      if (cmd.check) begin
         old_ff   <= ring_mem[old_idx];
         full_ff  <= (fill_ff >= eff_len);
         alert_ff <= 1'b0;
         if (fill_ff >= eff_len)
            med2_ff <= {1'b0, cell_ff[med_lo]} + {1'b0, cell_ff[med_hi]};
         else
            med2_ff <= '0;
      end
      if (cmd.del) begin
         alert_ff <= ({1'b0, samp_ff} >= med2_ff);
         for (int i = 0; i < WINDOW_MAX; i++) cell_ff[i] <= del_cell[i];
      end
      if (cmd.ins) begin
         ring_mem[head_ff] <= samp_ff;
         for (int i = 0; i < WINDOW_MAX; i++) cell_ff[i] <= ins_cell[i];
      end
      if (cmd.publish) begin
         rsp_full_ff  <= full_ff;
         rsp_med2_ff  <= med2_ff;
         rsp_alert_ff <= alert_ff;
         rsp_count_ff <= total_ff;
      end
   end

   // result word valid
   always_ff @(posedge clock) begin
      if (reset)                     rsp_valid_ff <= 1'b0;
      else if (cmd.publish)          rsp_valid_ff <= 1'b1;
      else if (rsp_ready)            rsp_valid_ff <= 1'b0;
   end

   assign sts = '{full: full_ff, out_free: (!rsp_valid_ff || rsp_ready)};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_full      = rsp_full_ff;
   assign rsp_median_times_two = rsp_med2_ff;
   assign rsp_alert            = rsp_alert_ff;
   assign rsp_alert_count      = rsp_count_ff;
endmodule
`default_nettype wire

/* src/sliding_window_median_alert_core.sv */
// Sliding window median alert, top level.
// The result word is registered on publish, which waits until the result register is free.
// The sequencer runs check, delete, insert and publish in turn over the sorted cell chain and
// the arrival ring memory, and takes no new word until it is back in idle.
// Reset (synchronous, active high): window empty, alert count zero, window length one.
// Ring and sorted cells hold no reset value; only written entries are read.
`default_nettype none
module sliding_window_median_alert_core #(
   parameter int WINDOW_MAX  = swma_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   swma_req_if.sink                           req_if,
   swma_rsp_if.source                         rsp_if,
   input  wire logic                          csr_we,
   input  wire logic [swma_pkg::LEN_BITS-1:0] csr_wdata
);
   swma_pkg::cmd_type cmd;
   swma_pkg::sts_type sts;
   logic              req_ready;

   assign req_if.ready = req_ready;

   swma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swma_dp #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_sample           (req_if.sample),
      .req_start_series     (req_if.start_series),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_if.valid),
      .rsp_ready            (rsp_if.ready),
      .rsp_window_full      (rsp_if.window_full),
      .rsp_median_times_two (rsp_if.median_times_two),
      .rsp_alert            (rsp_if.alert),
      .rsp_alert_count      (rsp_if.alert_count)
   );
endmodule
`default_nettype wire
